// ----- rtl/byte_buffer_pattern_search_assert.svh -----
// Assertion macros used by the byte buffer pattern search controller
`ifndef BYTE_BUFFER_PATTERN_SEARCH_ASSERT_SVH
`define BYTE_BUFFER_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define BBPS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbps assertion failed");

// next-cycle implication, clocked on clk, held off during reset
`define BBPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbps assertion failed");

`endif

// ----- rtl/bbps_pkg.sv -----
// Package: types and constants of the byte buffer pattern search
package bbps_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int PATTERN_MAX  = 16;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int LEN_W        = $clog2(PATTERN_MAX) + 1;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_MATCH  = 3'd3,
        CMD_PREFIX = 3'd4,
        CMD_SUFFIX = 3'd5
    } cmd_code_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_value;
        logic [7:0] start_offset;
    } cmd_word_t;

    typedef struct packed {
        logic       success;
        logic [7:0] position;
        logic [8:0] fill_count;
    } res_word_t;

    // controller to datapath
    typedef struct packed {
        logic push;
        logic clear;
        logic load;
        logic issue;
        logic finish;
        logic success;
        logic use_pos;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic scan_ok;
        logic issue_last;
        logic hit;
        logic data_last;
    } sts_t;

endpackage

// ----- rtl/bbps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
module bbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bbps_dp.sv -----
// Datapath: byte store, fill level, scan address, match window and result word
module bbps_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bbps_pkg::cmd_word_t       command,
    input  logic [63:0]               pattern_low,
    input  logic [63:0]               pattern_high,
    input  logic [4:0]                pattern_len,
    input  bbps_pkg::ctl_t            ctl,
    output bbps_pkg::sts_t            sts,
    output bbps_pkg::res_word_t       result
);
    import bbps_pkg::*;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [ADDR_W-1:0]  end_addr_reg;
    logic [ADDR_W-1:0]  data_addr_reg;
    logic               data_valid_reg;
    logic               data_last_reg;
    logic               search_reg;
    logic [LEN_W-1:0]   count_reg;
    logic [7:0]         win_reg  [PATTERN_MAX];
    logic [7:0]         win_next [PATTERN_MAX];
    logic [7:0]         pat      [PATTERN_MAX];
    res_word_t          result_reg;

    logic [LEN_W-1:0]   n;
    logic [LEN_W-1:0]   n_m1;
    logic [ADDR_W-1:0]  scan_start;
    logic [ADDR_W-1:0]  scan_end;
    logic               scan_ok;
    logic [ADDR_W+1:0]  off_plus_n;
    logic               n_fits;
    logic [7:0]         ram_rdata;
    logic               win_match;
    logic               cand_valid;
    logic [ADDR_W-1:0]  hit_pos;

    // effective pattern length, clamped to 1..PATTERN_MAX
    always_comb
    begin
        if (pattern_len == '0)
            n = LEN_W'(1);
        else if (pattern_len > LEN_W'(PATTERN_MAX))
            n = LEN_W'(PATTERN_MAX);
        else
            n = pattern_len;
    end

    assign n_m1 = n - LEN_W'(1);

    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (k < 8)
                pat[k] = pattern_low[8*k +: 8];
            else
                pat[k] = pattern_high[8*(k-8) +: 8];
        end
    end

    // scan window bounds per command
    assign off_plus_n = (ADDR_W+2)'(command.start_offset) + (ADDR_W+2)'(n);
    assign n_fits     = FILL_W'(n) <= fill_reg;

    always_comb
    begin
        scan_start = command.start_offset;
        scan_end   = ADDR_W'(fill_reg - FILL_W'(1));
        scan_ok    = 1'b0;
        unique case (cmd_code_t'(command.cmd))
            CMD_SEARCH:
            begin
                scan_ok = FILL_W'(command.start_offset) < fill_reg;
            end
            CMD_MATCH:
            begin
                scan_ok  = off_plus_n <= (ADDR_W+2)'(fill_reg);
                scan_end = ADDR_W'(off_plus_n - (ADDR_W+2)'(1));
            end
            CMD_PREFIX:
            begin
                scan_ok    = n_fits;
                scan_start = '0;
                scan_end   = ADDR_W'(n_m1);
            end
            CMD_SUFFIX:
            begin
                scan_ok    = n_fits;
                scan_start = ADDR_W'(fill_reg - FILL_W'(n));
            end
            default:
            begin
                scan_ok = 1'b0;
            end
        endcase
    end

    bbps_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctl.push && !sts.full),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (command.byte_value),
        .re    (ctl.issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // newest byte enters at n-1, older bytes move down
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (LEN_W'(k) == n_m1)
                win_next[k] = ram_rdata;
            else if (k < PATTERN_MAX - 1)
                win_next[k] = win_reg[(k < PATTERN_MAX - 1) ? k + 1 : k];
            else
                win_next[k] = win_reg[k];
        end
    end

    always_comb
    begin
        win_match = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((LEN_W'(k) < n) && (win_next[k] != pat[k]))
                win_match = 1'b0;
        end
    end

    assign cand_valid = count_reg >= n_m1;
    assign hit_pos    = data_addr_reg - ADDR_W'(n_m1);

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.clear)
            fill_next = '0;
        else if (ctl.push && !sts.full)
            fill_next = fill_reg + FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            data_valid_reg <= 1'b0;
            data_last_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            data_valid_reg <= ctl.issue;
            data_last_reg  <= ctl.issue && sts.issue_last;
            if (ctl.load)
                count_reg <= '0;
            else if (data_valid_reg && (count_reg < LEN_W'(PATTERN_MAX)))
                count_reg <= count_reg + LEN_W'(1);
        end
    end

    // only a search reports where the pattern was found
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rd_addr_reg  <= scan_start;
            end_addr_reg <= scan_end;
            search_reg   <= command.cmd == CMD_SEARCH;
        end
        else if (ctl.issue)
        begin
            rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
        end
        if (ctl.issue)
            data_addr_reg <= rd_addr_reg;
        if (data_valid_reg)
            win_reg <= win_next;
        if (ctl.finish)
        begin
            result_reg.success    <= ctl.success;
            result_reg.position   <= (ctl.use_pos && search_reg) ? hit_pos : '0;
            result_reg.fill_count <= fill_next;
        end
    end

    assign sts.full       = fill_reg == FILL_W'(BUFFER_DEPTH);
    assign sts.scan_ok    = scan_ok;
    assign sts.issue_last = rd_addr_reg == end_addr_reg;
    assign sts.hit        = data_valid_reg && cand_valid && win_match;
    assign sts.data_last  = data_valid_reg && data_last_reg;
    assign result         = result_reg;

endmodule

// ----- rtl/bbps_ctrl.sv -----
// Controller: command decode and scan sequencing state machine
`include "byte_buffer_pattern_search_assert.svh"

module bbps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bbps_pkg::cmd_word_t   command,
    input  bbps_pkg::sts_t        sts,
    output bbps_pkg::ctl_t        ctl,
    output logic                  busy,
    output logic                  done
);
    import bbps_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        ISSUE,
        DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_code_t'(command.cmd)) inside
                        CMD_PUSH:
                        begin
                            ctl.push    = 1'b1;
                            ctl.finish  = 1'b1;
                            ctl.success = !sts.full;
                        end
                        CMD_CLEAR:
                        begin
                            ctl.clear   = 1'b1;
                            ctl.finish  = 1'b1;
                            ctl.success = 1'b1;
                        end
                        CMD_SEARCH, CMD_MATCH, CMD_PREFIX, CMD_SUFFIX:
                        begin
                            if (sts.scan_ok)
                            begin
                                ctl.load   = 1'b1;
                                state_next = ISSUE;
                            end
                            else
                            begin
                                ctl.finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctl.finish = 1'b1;
                        end
                    endcase
                end
            end
            ISSUE, DRAIN:
            begin
                if (sts.hit)
                begin
                    ctl.finish  = 1'b1;
                    ctl.success = 1'b1;
                    ctl.use_pos = 1'b1;
                    state_next  = IDLE;
                end
                else if (sts.data_last)
                begin
                    ctl.finish = 1'b1;
                    state_next = IDLE;
                end
                else if (state_reg == ISSUE)
                begin
                    ctl.issue = 1'b1;
                    if (sts.issue_last)
                        state_next = DRAIN;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign done_next = ctl.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = state_reg != IDLE;
    assign done = done_reg;

    `BBPS_ASSERT_NOW(a_done_only_idle, done_reg, state_reg == IDLE)
    `BBPS_ASSERT_NEXT(a_hit_ends_scan, (state_reg != IDLE) && sts.hit,
                      done_reg && state_reg == IDLE)
    `BBPS_ASSERT_NOW(a_no_issue_in_drain, state_reg == DRAIN, !ctl.issue)
    `BBPS_ASSERT_NEXT(a_load_starts_scan, ctl.load, state_reg == ISSUE && !done_reg)

endmodule

// ----- rtl/byte_buffer_pattern_search.sv -----
// Top level: configuration registers, controller and datapath
//
//  channel   signals                          handshake
//  command   start, busy, command             taken when start && !busy
//  result    done, result                     one cycle on done, no stall
//  config    cfg_we, cfg_index, cfg_data      written when cfg_we is high
//
// Push, clear and unused codes: result in the cycle after the word is taken.
// Search and single-place tests scan the byte RAM one address per cycle,
// one candidate tested per cycle; a hit ends the scan early.
// A search from at or past the fill level, or a single-place test whose
// pattern would run past it, fails at once.
// Reset empties the buffer and sets the pattern length to 1.
module byte_buffer_pattern_search (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bbps_pkg::cmd_word_t                command,
    output logic                               done,
    output bbps_pkg::res_word_t                result,
    input  logic                               cfg_we,
    input  logic [bbps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbps_pkg::CFG_W-1:0]         cfg_data
);
    import bbps_pkg::*;

    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [4:0]  pat_len_reg;
    ctl_t        ctl;
    sts_t        sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    bbps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    bbps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .pattern_low  (pat_low_reg),
        .pattern_high (pat_high_reg),
        .pattern_len  (pat_len_reg),
        .ctl          (ctl),
        .sts          (sts),
        .result       (result)
    );

endmodule
